// ----- hw/rtl/cfd_pkg.sv -----
// Shared types and constants for the COBS frame decoder.
package cfd_pkg;

   localparam int BYTE_BITS          = 8;
   localparam int LIMIT_BITS         = 16;
   localparam int COUNT_OUT_BITS     = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int FIFO_DEPTH         = 4;
   localparam int CSR_ADDR_BITS      = 2;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [BYTE_BITS-1:0]     CODE_MAX          = 8'hFF;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_OUTPUT_LIMIT = 2'd0;

   typedef struct packed {
      logic [BYTE_BITS-1:0]      dec_byte;
      logic                      byte_valid;
      logic                      run_last;
      logic                      frame_end;
      logic [COUNT_OUT_BITS-1:0] decoded_count;
   } result_type;

   // Up to two results pushed per decoded item.
   typedef struct packed {
      logic       first;
      logic       second;
      result_type first_res;
      result_type second_res;
   } push_type;

endpackage

// ----- hw/rtl/cfd_if.sv -----
// Handshake channel interfaces for encoded input and decoded output items.
interface cfd_req_if;
   logic                          valid;
   logic                          ready;
   logic [cfd_pkg::BYTE_BITS-1:0] enc_byte;
   logic                          frame_last;

   modport source (output valid, output enc_byte, output frame_last, input ready);
   modport sink   (input valid, input enc_byte, input frame_last, output ready);
endinterface

interface cfd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cfd_pkg::BYTE_BITS-1:0]      dec_byte;
   logic                               byte_valid;
   logic                               run_last;
   logic                               frame_end;
   logic [cfd_pkg::COUNT_OUT_BITS-1:0] decoded_count;

   modport source (output valid, output dec_byte, output byte_valid, output run_last,
                   output frame_end, output decoded_count, input ready);
   modport sink   (input valid, input dec_byte, input byte_valid, input run_last,
                   input frame_end, input decoded_count, output ready);
endinterface

// ----- hw/rtl/cfd_out_fifo.sv -----
// Result queue: takes one or two results per cycle, hands out one.
module cfd_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  cfd_pkg::push_type    push,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cfd_pkg::result_type  out_res
);

   localparam int PTR_BITS = $clog2(cfd_pkg::FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(cfd_pkg::FIFO_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] ROOM_MAX = CNT_BITS'(cfd_pkg::FIFO_DEPTH - 2);

   cfd_pkg::result_type       mem_ff [cfd_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic                      pop;
   logic [PTR_BITS-1:0]       wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= ROOM_MAX);
   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.first) + PTR_BITS'(push.second);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push.first) + CNT_BITS'(push.second)
                  - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= push.first_res;
      end
      if (push.second) begin
         mem_ff[wr_next] <= push.second_res;
      end
   end

endmodule

// ----- hw/rtl/cfd_decode_core.sv -----
// Decode stage: registered input byte, segment state, output limit and count logic.
module cfd_decode_core #(
   parameter int COUNT_BITS = cfd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [cfd_pkg::BYTE_BITS-1:0]    enc_byte,
   input  logic                             frame_last,
   input  logic [cfd_pkg::LIMIT_BITS-1:0]   output_limit,
   input  logic                             has_room,
   output cfd_pkg::push_type                push
);

   localparam int CMP_BITS = (COUNT_BITS > cfd_pkg::LIMIT_BITS) ?
                             COUNT_BITS : cfd_pkg::LIMIT_BITS;
   localparam logic [CMP_BITS-1:0] OUT_MAX =
      CMP_BITS'({cfd_pkg::COUNT_OUT_BITS{1'b1}});

   // input stage
   logic                          stage_valid_ff, stage_valid_in;
   logic [cfd_pkg::BYTE_BITS-1:0] stage_byte_ff;
   logic                          stage_last_ff;
   logic                          fire;

   // decoder state
   logic [cfd_pkg::BYTE_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                          code_was_max_ff, code_was_max_in;
   logic [COUNT_BITS-1:0]         out_count_ff, out_count_in;
   logic                          output_full_ff, output_full_in;

   logic [COUNT_BITS-1:0]         cnt1, cnt2;
   logic                          hit0, hit1, hit2;
   logic                          try1, try2, emit1, emit2;
   logic                          is_code;
   logic [cfd_pkg::BYTE_BITS-1:0] left_dec;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + COUNT_BITS'(1);
   endfunction

   function automatic logic hit_at(input logic [COUNT_BITS-1:0] c,
                                   input logic [cfd_pkg::LIMIT_BITS-1:0] lim);
      return (lim != '0) && (CMP_BITS'(c) >= CMP_BITS'(lim));
   endfunction

   function automatic logic [cfd_pkg::COUNT_OUT_BITS-1:0] clamp_count(
      input logic [COUNT_BITS-1:0] c);
      logic [CMP_BITS-1:0] w;
      w = CMP_BITS'(c);
      return (w > OUT_MAX) ? '1 : w[cfd_pkg::COUNT_OUT_BITS-1:0];
   endfunction

   assign fire     = stage_valid_ff && has_room;
   assign in_ready = !stage_valid_ff || fire;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (in_valid && in_ready) begin
         stage_valid_in = 1'b1;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_byte_ff <= enc_byte;
         stage_last_ff <= frame_last;
      end
   end

   // Emission chain: first and second byte attempts against the limit.
   always_comb begin
      is_code  = (bytes_left_ff == '0);
      left_dec = bytes_left_ff - cfd_pkg::BYTE_BITS'(1);
      cnt1     = sat_inc(out_count_ff);
      cnt2     = sat_inc(cnt1);
      hit0     = hit_at(out_count_ff, output_limit);
      hit1     = hit_at(cnt1, output_limit);
      hit2     = hit_at(cnt2, output_limit);

      if (is_code) begin
         try1 = (stage_byte_ff <= cfd_pkg::BYTE_BITS'(1)) ||
                (stage_last_ff && (stage_byte_ff != cfd_pkg::CODE_MAX));
         try2 = 1'b0;
      end else begin
         try1 = 1'b1;
         try2 = !code_was_max_ff && ((left_dec == '0) || stage_last_ff);
      end
      try1  = try1 && !output_full_ff;
      emit1 = try1 && !hit0;
      emit2 = emit1 && try2 && !hit1;

      bytes_left_in   = bytes_left_ff;
      code_was_max_in = code_was_max_ff;
      out_count_in    = out_count_ff;
      output_full_in  = output_full_ff;

      if (!output_full_ff) begin
         if (is_code) begin
            code_was_max_in = (stage_byte_ff == cfd_pkg::CODE_MAX);
            bytes_left_in   = (stage_byte_ff <= cfd_pkg::BYTE_BITS'(1)) ?
                              '0 : stage_byte_ff - cfd_pkg::BYTE_BITS'(1);
         end else begin
            bytes_left_in = left_dec;
         end
         if (try1) begin
            output_full_in = hit0 || hit1;
         end
         if (emit1 && try2) begin
            output_full_in = hit1 || hit2;
         end
         if (emit2) begin
            out_count_in = cnt2;
         end else if (emit1) begin
            out_count_in = cnt1;
         end
      end

      if (stage_last_ff) begin
         bytes_left_in   = '0;
         code_was_max_in = 1'b0;
         out_count_in    = '0;
         output_full_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff   <= '0;
         code_was_max_ff <= 1'b0;
         out_count_ff    <= '0;
         output_full_ff  <= 1'b0;
      end else if (fire) begin
         bytes_left_ff   <= bytes_left_in;
         code_was_max_ff <= code_was_max_in;
         out_count_ff    <= out_count_in;
         output_full_ff  <= output_full_in;
      end
   end

   // With two bytes the first count is taken one below the final count,
   // also when the counter has saturated.
   always_comb begin
      push.first  = fire;
      push.second = fire && emit2;

      push.first_res.dec_byte   = (emit1 && !is_code) ? stage_byte_ff : '0;
      push.first_res.byte_valid = emit1;
      push.first_res.run_last   = !emit2;
      push.first_res.frame_end  = stage_last_ff && !emit2;
      if (emit2) begin
         push.first_res.decoded_count = clamp_count(cnt2 - COUNT_BITS'(1));
      end else if (emit1) begin
         push.first_res.decoded_count = clamp_count(cnt1);
      end else begin
         push.first_res.decoded_count = clamp_count(out_count_ff);
      end

      push.second_res.dec_byte      = '0;
      push.second_res.byte_valid    = 1'b1;
      push.second_res.run_last      = 1'b1;
      push.second_res.frame_end     = stage_last_ff;
      push.second_res.decoded_count = clamp_count(cnt2);
   end

endmodule

// ----- hw/rtl/cobs_frame_decoder.sv -----
// Top level of the COBS frame decoder: channels, limit register, decode core, result queue.
// An accepted item is held in the input stage and decoded once the result queue has room;
// its results are registered in the result queue and offered on rsp_ch from there.
// Throughput: one item per cycle while items yield one result each and the queue has room;
// an item yielding two results needs an extra output slot, absorbed by the four-entry queue.
// Reset (synchronous, active high) clears the segment state, counters, queue and limit.
module cobs_frame_decoder #(
   parameter int COUNT_BITS = cfd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cfd_req_if.sink                             req_ch,
   cfd_rsp_if.source                           rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cfd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [cfd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [cfd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   logic [cfd_pkg::LIMIT_BITS-1:0] output_limit_ff, output_limit_in;
   logic                           csr_write;
   logic                           has_room;
   cfd_pkg::push_type              push;
   cfd_pkg::result_type            out_res;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr == cfd_pkg::ADDR_OUTPUT_LIMIT);
   assign prdata    = (paddr == cfd_pkg::ADDR_OUTPUT_LIMIT) ?
                      cfd_pkg::CSR_DATA_BITS'(output_limit_ff) : '0;

   always_comb begin
      output_limit_in = output_limit_ff;
      if (csr_write) begin
         output_limit_in = pwdata[cfd_pkg::LIMIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_limit_ff <= '0;
      end else begin
         output_limit_ff <= output_limit_in;
      end
   end

   cfd_decode_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .enc_byte     (req_ch.enc_byte),
      .frame_last   (req_ch.frame_last),
      .output_limit (output_limit_ff),
      .has_room     (has_room),
      .push         (push)
   );

   cfd_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_res   (out_res)
   );

   assign rsp_ch.dec_byte      = out_res.dec_byte;
   assign rsp_ch.byte_valid    = out_res.byte_valid;
   assign rsp_ch.run_last      = out_res.run_last;
   assign rsp_ch.frame_end     = out_res.frame_end;
   assign rsp_ch.decoded_count = out_res.decoded_count;

endmodule
